// ===== design/bba_pkg.sv =====
// Shared types, constants and codes for the bitmap block allocator.
// Used by every module of the design; depends on nothing.
package bba_pkg;

    localparam int MAP_BLOCKS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAP_BLOCKS / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(MAP_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FEW     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_RUN  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd3;

    localparam logic [APB_AW-3:0] REG_TOTAL_BLOCKS = 1'b0;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic                 hit;
        logic [BIT_IDX_W-1:0] pos;
        logic [CNT_W-1:0]     run_out;
    } t_scan_res;

    typedef struct packed {
        logic             en;
        logic             set;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
    } t_edit_ctl;

endpackage

// ===== design/bba_cell.sv =====
// One cell of the bitmap ring: holds one word of the usage bitmap.
// Depends on bba_pkg for the word type.
module bba_cell
    import bba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  logic  i_shift,
    input  t_word i_d,
    output t_word o_q
);

    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '1;
        end else if (i_clear) begin
            r_word <= '1;
        end else if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// ===== design/bba_scan.sv =====
// Free-run search over the bitmap word at the head of the ring.
// Depends on bba_pkg for the word type and the scan result struct.
module bba_scan
    import bba_pkg::*;
(
    input  t_word            i_word,
    input  logic [CNT_W-1:0] i_run,
    input  logic [CNT_W-1:0] i_count,
    output t_scan_res        o_res
);

    t_word                   free_bits;
    t_word                   pw [BIT_IDX_W+1];
    t_word                   acc;
    t_word                   pre;
    t_word                   low_used;
    t_word                   hit;
    logic                    empty;
    logic signed [CNT_W:0]   need;
    logic [BIT_IDX_W-1:0]    pos;
    logic [BIT_IDX_W-1:0]    top;

    always_comb begin
        free_bits = ~i_word;
        pw[0] = free_bits;
        for (int k = 1; k <= BIT_IDX_W; k++) begin
            pw[k] = pw[k-1] & (pw[k-1] << (1 << (k - 1)));
        end

        acc   = '1;
        empty = 1'b1;
        for (int k = 0; k <= BIT_IDX_W; k++) begin
            if (i_count[k]) begin
                acc   = pw[k] & (empty ? '1 : (acc << (1 << k)));
                empty = 1'b0;
            end
        end
        if (i_count[CNT_W-1:BIT_IDX_W+1] != '0) begin
            acc = '0;
        end

        low_used = i_word & (~i_word + t_word'(1));
        pre      = low_used - t_word'(1);
        need     = $signed({1'b0, i_count}) - $signed({1'b0, i_run}) - (CNT_W+1)'(1);

        for (int j = 0; j < WORD_BITS; j++) begin
            hit[j] = acc[j] | (pre[j] & ($signed((CNT_W+1)'(j)) >= need));
        end

        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                pos = BIT_IDX_W'(j);
            end
        end

        top = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (i_word[j]) begin
                top = BIT_IDX_W'(j);
            end
        end

        o_res.hit = |hit;
        o_res.pos = pos;
        if (i_word == '0) begin
            o_res.run_out = i_run + CNT_W'(WORD_BITS);
        end else begin
            o_res.run_out = CNT_W'(WORD_BITS - 1) - CNT_W'(top);
        end
    end

endmodule

// ===== design/bba_edit.sv =====
// Range set/clear of the bitmap word leaving the head of the ring.
// Depends on bba_pkg for the word type and the edit control struct.
module bba_edit
    import bba_pkg::*;
(
    input  t_word            i_word,
    input  t_edit_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_base,
    output t_word            o_word
);

    function automatic logic [BIT_IDX_W:0] clamp_off(logic [CNT_W-1:0] pos_v,
                                                     logic [CNT_W-1:0] base_v);
        logic signed [CNT_W:0] off;
        off = $signed({1'b0, pos_v}) - $signed({1'b0, base_v});
        if (off < 0) begin
            return '0;
        end else if (off > $signed((CNT_W+1)'(WORD_BITS))) begin
            return (BIT_IDX_W+1)'(WORD_BITS);
        end
        return off[BIT_IDX_W:0];
    endfunction

    logic [WORD_BITS:0] ones_ext;
    logic [WORD_BITS:0] ge_lo;
    logic [WORD_BITS:0] ge_hi;
    t_word              mask;

    always_comb begin
        ones_ext = '1;
        ge_lo    = ones_ext << clamp_off(i_ctl.lo, i_base);
        ge_hi    = ones_ext << clamp_off(i_ctl.hi, i_base);
        mask     = ge_lo[WORD_BITS-1:0] & ~ge_hi[WORD_BITS-1:0];
        if (!i_ctl.en) begin
            o_word = i_word;
        end else if (i_ctl.set) begin
            o_word = i_word | mask;
        end else begin
            o_word = i_word & ~mask;
        end
    end

endmodule

// ===== design/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: request decode, ring control, APB register.
// Depends on bba_pkg, bba_cell, bba_scan and bba_edit.
//
// A request is taken at a rising edge where i_start is high and o_busy is low.
// Each request gives exactly one result, shown for one cycle with o_valid high;
// the receiver cannot hold it off. The usage bitmap sits in a ring of 32 cells,
// one word each, which rotates one word per cycle during a search or marking pass
// past a shared search unit and a shared range editor; a full pass sees every word once.
// A zero count, an unused action or an allocate with too few free blocks gives
// its result in the cycle after accept. Release, reserve or an allocate that
// finds no contiguous run takes one pass; a successful allocate takes one search
// pass and one marking pass. A new request may be taken in the cycle its
// predecessor's result is shown. Reset and every write of total_blocks mark all
// blocks used and set the used count to the managed size. The user must write
// total_blocks only while idle; the block itself does not enforce it.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [ACT_W-1:0]   i_action,
    input  logic [IDX_W-1:0]   i_block_index,
    input  logic [CNT_W-1:0]   i_block_count,
    output logic               o_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [IDX_W-1:0]   o_start_block,
    output logic [CNT_W-1:0]   o_free_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_MARK   = 2'd2;

    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

    logic [1:0]            r_state,  n_state;
    logic [WORD_IDX_W-1:0] r_cnt,    n_cnt;
    logic                  r_alloc,  n_alloc;
    logic                  r_set,    n_set;
    logic                  r_found,  n_found;
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [CNT_W-1:0]      r_lo,     n_lo;
    logic [CNT_W-1:0]      r_hi,     n_hi;
    logic [CNT_W-1:0]      r_len,    n_len;
    logic [CNT_W-1:0]      r_run,    n_run;
    logic [CNT_W-1:0]      r_used,   n_used;
    logic [CNT_W-1:0]      r_total,  n_total;
    logic [CNT_W-1:0]      r_t,      n_t;
    logic                  r_valid,  n_valid;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [IDX_W-1:0]      r_start,  n_start;
    logic [CNT_W-1:0]      r_free,   n_free;

    logic                  accept;
    logic                  cfg_wr;
    logic                  shift;
    logic [CNT_W-1:0]      free_now;
    logic [CNT_W-1:0]      base;
    logic [CNT_W-1:0]      start_calc;
    logic [CNT_W:0]        range_end;
    logic [CNT_W-1:0]      range_hi;
    logic [CNT_W:0]        used_sum;
    logic [CNT_W-1:0]      used_next;
    t_word                 cell_q [MAP_WORDS];
    t_word                 edit_word;
    t_scan_res             scan;
    t_edit_ctl             edit_ctl;

    assign accept   = i_start && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[APB_AW-1:2] == REG_TOTAL_BLOCKS);
    assign shift    = (r_state == S_SEARCH) || (r_state == S_MARK);
    assign free_now = r_t - r_used;
    assign base     = CNT_W'({r_cnt, {BIT_IDX_W{1'b0}}});

    genvar gi;
    generate
        for (gi = 0; gi < MAP_WORDS; gi++) begin : g_cell
            if (gi == MAP_WORDS - 1) begin : g_tail
                bba_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (cfg_wr),
                    .i_shift (shift),
                    .i_d     (edit_word),
                    .o_q     (cell_q[gi])
                );
            end else begin : g_body
                bba_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_clear (cfg_wr),
                    .i_shift (shift),
                    .i_d     (cell_q[gi+1]),
                    .o_q     (cell_q[gi])
                );
            end
        end
    endgenerate

    bba_scan u_scan (
        .i_word  (cell_q[0]),
        .i_run   (r_run),
        .i_count (r_count),
        .o_res   (scan)
    );

    assign edit_ctl.en  = (r_state == S_MARK);
    assign edit_ctl.set = r_set;
    assign edit_ctl.lo  = r_lo;
    assign edit_ctl.hi  = r_hi;

    bba_edit u_edit (
        .i_word (cell_q[0]),
        .i_ctl  (edit_ctl),
        .i_base (base),
        .o_word (edit_word)
    );

    always_comb begin
        start_calc = CNT_W'({r_cnt, scan.pos}) + CNT_W'(1) - r_count;
        range_end  = {2'b0, i_block_index} + {1'b0, i_block_count};
        range_hi   = (range_end > {1'b0, r_t}) ? r_t : range_end[CNT_W-1:0];
        used_sum   = {1'b0, r_used} + {1'b0, r_len};
        if (r_set) begin
            used_next = (used_sum > {1'b0, r_t}) ? r_t : used_sum[CNT_W-1:0];
        end else begin
            used_next = (r_len > r_used) ? '0 : r_used - r_len;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_alloc  = r_alloc;
        n_set    = r_set;
        n_found  = r_found;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_len    = r_len;
        n_run    = r_run;
        n_used   = r_used;
        n_total  = r_total;
        n_t      = r_t;
        n_valid  = 1'b0;
        n_status = r_status;
        n_start  = r_start;
        n_free   = r_free;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = STAT_OK;
                    n_start  = '0;
                    n_free   = free_now;
                    if (i_block_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = STAT_ZERO;
                    end else if (i_action == ACT_ALLOC) begin
                        if (i_block_count > free_now) begin
                            n_valid  = 1'b1;
                            n_status = STAT_FEW;
                        end else begin
                            n_state = S_SEARCH;
                            n_count = i_block_count;
                            n_len   = i_block_count;
                            n_run   = '0;
                            n_found = 1'b0;
                            n_alloc = 1'b1;
                            n_set   = 1'b1;
                        end
                    end else if (i_action inside {ACT_RELEASE, ACT_RESERVE}) begin
                        n_state = S_MARK;
                        n_alloc = 1'b0;
                        n_set   = (i_action == ACT_RESERVE);
                        n_count = i_block_count;
                        n_lo    = {1'b0, i_block_index};
                        n_hi    = range_hi;
                        n_len   = ({1'b0, i_block_index} < range_hi)
                                  ? range_hi - {1'b0, i_block_index} : '0;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                n_cnt = r_cnt + WORD_IDX_W'(1);
                n_run = scan.run_out;
                if (!r_found && scan.hit) begin
                    n_found = 1'b1;
                    n_lo    = start_calc;
                    n_hi    = start_calc + r_count;
                end
                if (r_cnt == LAST_WORD) begin
                    if (r_found || scan.hit) begin
                        n_state = S_MARK;
                    end else begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = STAT_NO_RUN;
                        n_start  = '0;
                        n_free   = free_now;
                    end
                end
            end
            S_MARK: begin
                n_cnt = r_cnt + WORD_IDX_W'(1);
                if (r_cnt == LAST_WORD) begin
                    n_state  = S_IDLE;
                    n_used   = used_next;
                    n_valid  = 1'b1;
                    n_status = STAT_OK;
                    n_start  = r_alloc ? r_lo[IDX_W-1:0] : '0;
                    n_free   = r_t - used_next;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase

        if (cfg_wr) begin
            n_total = pwdata[CNT_W-1:0];
            n_t     = (pwdata[CNT_W-1:0] > CNT_W'(MAP_BLOCKS))
                      ? CNT_W'(MAP_BLOCKS) : pwdata[CNT_W-1:0];
            n_used  = n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
            r_used  <= CNT_W'(MAP_BLOCKS);
            r_total <= CNT_W'(MAP_BLOCKS);
            r_t     <= CNT_W'(MAP_BLOCKS);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_valid <= n_valid;
            r_used  <= n_used;
            r_total <= n_total;
            r_t     <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alloc  <= n_alloc;
        r_set    <= n_set;
        r_count  <= n_count;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_len    <= n_len;
        r_run    <= n_run;
        r_status <= n_status;
        r_start  <= n_start;
        r_free   <= n_free;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_start_block = r_start;
    assign o_free_count  = r_free;
    assign pready        = 1'b1;
    assign prdata        = (paddr[APB_AW-1:2] == REG_TOTAL_BLOCKS)
                           ? APB_DW'(r_total) : '0;

`ifndef NO_ASSERTIONS
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while a request is still in progress");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_count <= r_t))
        else $error("free count exceeds managed blocks");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("ring not back at home position while idle");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_t)
        else $error("used count exceeds managed blocks");
`endif

endmodule
